>>> sv/ordered_array_list_engine_macros.svh
// Assertion macros used by the sequencer of the ordered array list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/oal_pkg.sv
// Package with word types and codes for the ordered array list engine.
`timescale 1ns / 1ps
`default_nettype none

package oal_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 9;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;
    localparam logic [1:0] ACT_MODIFY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] count;
    } rsp_t;

endpackage

`default_nettype wire

>>> sv/ordered_array_list_engine.sv
// Top level of the ordered array list engine: sequencer plus entry store.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Signals                       Word
// request    req_valid, req_ready, req     action, position, value
// response   rsp_valid, rsp_ready, rsp     status, found_index, count
//
// One request is in flight at a time; a new one is taken while the previous
// response still sits in the output register. An insert below the end shifts
// the later entries up by one, an erase shifts them down, a find compares from
// index 0 on, and a modify writes in place. The entry store has one read and
// one write port, and one element is moved or compared per cycle. Reset clears
// the count and control state; the entry store needs no clearing pass. A
// stalled response holds the block in its response state until the output
// register frees up.

module ordered_array_list_engine
    import oal_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);

    // The sequencer drives a single write port and a single read port.
    // Shifts stream through the read data register, one entry per cycle.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    oal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Entries beyond the count are never read, so the store has no reset.
    oal_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

>>> sv/oal_mem.sv
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oal_mem
    import oal_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/oal_ctrl.sv
// Sequencer that walks the entry store for insert, erase, find and modify.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_array_list_engine_macros.svh"

module oal_ctrl
    import oal_pkg::*;
#(
    parameter int CAPACITY = 256,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rsp_t                   rsp,
    output logic                   mem_we,
    output logic      [AW-1:0]     mem_waddr,
    output logic      [DATA_W-1:0] mem_wdata,
    output logic                   mem_re,
    output logic      [AW-1:0]     mem_raddr,
    input  wire logic [DATA_W-1:0] mem_rdata
);

    localparam int W = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHUP  = 3'd1;
    localparam logic [2:0] S_SHDN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    // Control state.
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wb_valid_reg, wb_valid_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          issue_done_reg, issue_done_next;
    logic          inc_reg, inc_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state.
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [AW-1:0]     wb_addr_reg, wb_addr_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [1:0]        st_reg, st_next;
    logic [AW-1:0]     fidx_reg, fidx_next;
    rsp_t              out_data_reg, out_data_next;

    logic [W-1:0]      pos_w, cnt_w, cnt_m1_w;
    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     pos_idx;
    logic              list_full;
    logic [AW+7:0]     fidx_ext;
    logic [CW+8:0]     cnt_ext;

    assign pos_w     = W'(req.position);
    assign cnt_w     = W'(count_reg);
    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_m1_w  = W'(cnt_m1);
    assign pos_idx   = AW'(req.position);
    assign list_full = (count_reg == CW'(CAPACITY));
    assign fidx_ext  = {8'b0, fidx_reg};
    assign cnt_ext   = {9'b0, count_reg};

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        wb_valid_next   = 1'b0;
        cmp_valid_next  = 1'b0;
        issue_done_next = issue_done_reg;
        inc_next        = inc_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        wb_addr_next    = wb_addr_reg;
        cmp_idx_next    = cmp_idx_reg;
        st_next         = st_reg;
        fidx_next       = fidx_reg;
        out_data_next   = out_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;

        // A pending shift write-back always owns the write port.
        mem_we    = wb_valid_reg;
        mem_waddr = wb_addr_reg;
        mem_wdata = mem_rdata;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next   = pos_idx;
                    val_next   = req.value;
                    st_next    = ST_OK;
                    fidx_next  = '0;
                    state_next = S_RESP;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            if (pos_w > cnt_w)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else if (list_full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (pos_w < cnt_w)
                            begin
                                idx_next   = AW'(cnt_m1);
                                inc_next   = 1'b1;
                                state_next = S_SHUP;
                            end
                            else
                            begin
                                inc_next   = 1'b1;
                                state_next = S_WRITE;
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else if (cnt_m1_w > pos_w)
                            begin
                                idx_next   = pos_idx + 1'b1;
                                state_next = S_SHDN;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                idx_next        = '0;
                                issue_done_next = 1'b0;
                                state_next      = S_FIND;
                            end
                        end
                        default:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                inc_next   = 1'b0;
                                state_next = S_WRITE;
                            end
                        end
                    endcase
                end
            end
            S_SHUP:
            begin
                // Read entry i now, write it to i+1 in the next cycle.
                mem_re        = 1'b1;
                wb_valid_next = 1'b1;
                wb_addr_next  = idx_reg + 1'b1;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SHDN:
            begin
                // Read entry i now, write it to i-1 in the next cycle.
                mem_re        = 1'b1;
                wb_valid_next = 1'b1;
                wb_addr_next  = idx_reg - 1'b1;
                if (CW'(idx_reg) == cnt_m1)
                begin
                    count_next = cnt_m1;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                if (!wb_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = val_reg;
                    if (inc_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end
            end
            S_FIND:
            begin
                if (cmp_valid_reg && (mem_rdata == val_reg))
                begin
                    fidx_next  = cmp_idx_reg;
                    state_next = S_RESP;
                end
                else if (cmp_valid_reg && (CW'(cmp_idx_reg) == cnt_m1))
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_RESP;
                end
                else if (!issue_done_reg)
                begin
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                    if (CW'(idx_reg) == cnt_m1)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = st_reg;
                    out_data_next.found_index = fidx_ext[IDX_W-1:0];
                    out_data_next.count       = cnt_ext[CNT_W-1:0];
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            wb_valid_reg   <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            inc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            wb_valid_reg   <= wb_valid_next;
            cmp_valid_reg  <= cmp_valid_next;
            issue_done_reg <= issue_done_next;
            inc_reg        <= inc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        wb_addr_reg  <= wb_addr_next;
        cmp_idx_reg  <= cmp_idx_next;
        st_reg       <= st_next;
        fidx_reg     <= fidx_next;
        out_data_reg <= out_data_next;
    end

    `OAL_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `OAL_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "count moved by more than one")
    `OAL_ASSERT_IMP(a_idle_drained, clk, rst_n, req_ready, !wb_valid_reg, "write-back pending while idle")
    `OAL_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
    `OAL_ASSERT_NEXT(a_accept_busy, clk, rst_n, req_valid && req_ready, state_reg != S_IDLE, "accepted word left no work")

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the ordered array list engine.
`timescale 1ns / 1ps

module tb;
    import oal_pkg::*;

    localparam int CAPACITY   = 256;
    localparam int IDLE_LIMIT = 4000;  // cycles without any handshake
    localparam int TAIL_WAIT  = 300;   // longer than a full-list find
    localparam int DIR_N      = 27;

    // One row of the directed script: the request word, and optionally the
    // response typed in by hand instead of taken from the list predictor.
    typedef struct packed {
        req_t word;
        logic typed;
        rsp_t want;
    } script_row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req_word  = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp_word;

    // Shadow copy of the list, advanced once for every accepted request.
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;

    rsp_t        pending_rsp [$];
    script_row_t cur_row;
    script_row_t directed_rows [DIR_N];
    bit          taken;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          mismatch_count = 0;
    int          idle_run = 0;

    ordered_array_list_engine DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic req_t make_word(logic [1:0] act, int pos, logic [DATA_W-1:0] val);
        req_t w;
        w.action   = act;
        w.position = POS_W'(pos);
        w.value    = val;
        return w;
    endfunction

    function automatic script_row_t row(logic [1:0] act, int pos, logic [DATA_W-1:0] val,
                                        logic typed, logic [1:0] st, int idx, int cnt);
        script_row_t r;
        r.word             = make_word(act, pos, val);
        r.typed            = typed;
        r.want.status      = st;
        r.want.found_index = IDX_W'(idx);
        r.want.count       = CNT_W'(cnt);
        return r;
    endfunction

    // Applies one request to the shadow list and returns the response the
    // block must give for it.
    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int   p;
        o = '0;
        p = int'(r.position);
        case (r.action)
            ACT_INSERT:
            begin
                if (p > list_len)
                    o.status = ST_BADPOS;
                else if (list_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = r.value;
                    list_len++;
                    o.status = ST_OK;
                end
            end
            ACT_ERASE:
            begin
                if (p >= list_len)
                    o.status = ST_BADPOS;
                else
                begin
                    for (int i = p; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    o.status = ST_OK;
                end
            end
            ACT_FIND:
            begin
                o.status = ST_NOTFOUND;
                for (int i = 0; i < list_len; i++)
                begin
                    if (o.status == ST_NOTFOUND && list_mem[i] == r.value)
                    begin
                        o.status      = ST_OK;
                        o.found_index = IDX_W'(i);
                    end
                end
            end
            default:
            begin
                if (p >= list_len)
                    o.status = ST_BADPOS;
                else
                begin
                    list_mem[p] = r.value;
                    o.status    = ST_OK;
                end
            end
        endcase
        o.count = CNT_W'(list_len);
        return o;
    endfunction

    // Values lean toward a small pool so that finds hit and duplicates occur.
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2)
            return DATA_W'($urandom_range(0, 7));
        if (r == 2)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // A mostly well-formed request for the current list length, with some
    // out-of-range positions and raw noise mixed in.
    function automatic req_t pick_request();
        int r;
        int pos;
        r = $urandom_range(0, 99);
        if (r < 8)
            return make_word(2'($urandom), int'($urandom_range(0, 511)), $urandom);
        if (r < 14)
        begin
            pos = list_len + int'($urandom_range(0, 3));
            return make_word(2'($urandom_range(0, 3)), pos, pick_value());
        end
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0: pos = 0;
                1: pos = list_len;
                default: pos = int'($urandom_range(0, list_len));
            endcase
            return make_word(ACT_INSERT, pos, pick_value());
        end
        if (r < 72 && list_len > 0)
            return make_word(ACT_ERASE, int'($urandom_range(0, list_len - 1)), $urandom);
        if (r < 88)
        begin
            if (list_len > 0 && $urandom_range(0, 2) != 0)
                return make_word(ACT_FIND, int'($urandom_range(0, 511)),
                                 list_mem[$urandom_range(0, list_len - 1)]);
            return make_word(ACT_FIND, int'($urandom_range(0, 511)), pick_value());
        end
        if (list_len > 0)
            return make_word(ACT_MODIFY, int'($urandom_range(0, list_len - 1)), pick_value());
        return make_word(ACT_MODIFY, 0, pick_value());
    endfunction

    // Advances one clock. Handshakes are judged on the values held before the
    // edge, so the predictor and the checker see exactly what the block saw.
    task automatic tick();
        rsp_t want;
        @(posedge clk);
        if (req_valid && req_ready)
        begin
            want = list_apply(req_word);
            if (cur_row.typed)
                want = cur_row.want;
            pending_rsp.push_back(want);
            taken = 1'b1;
        end
        if (rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected response word: status %0d index %0d count %0d",
                             rsp_word.status, rsp_word.found_index, rsp_word.count);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_word.status !== want.status
                    || rsp_word.found_index !== want.found_index
                    || rsp_word.count !== want.count)
                begin
                    if (mismatch_count < 10)
                        $display("response mismatch: expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
                                 want.status, want.found_index, want.count,
                                 rsp_word.status, rsp_word.found_index, rsp_word.count);
                    mismatch_count++;
                end
            end
        end
        // The receiver switches between stretches of full speed, random
        // stalls, heavy stalls and a fixed two-in-eight stall pattern.
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((stall_left % 8) > 1);
        endcase
    endtask

    // Sends one request word. The sender works in bursts; between bursts it
    // drops valid for a random gap.
    task automatic send_word(script_row_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) tick();
            end
            burst_left = $urandom_range(1, 16);
        end
        cur_row   = r;
        req_valid <= 1'b1;
        req_word  <= r.word;
        taken     = 1'b0;
        do
            tick();
        while (!taken);
        burst_left--;
    endtask

    function automatic script_row_t checked_row(req_t w);
        script_row_t r;
        r       = '0;
        r.word  = w;
        return r;
    endfunction

    // Watchdog: any handshake on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run == IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed script, starting from an empty list. Rows with a typed
        // response cover reset, the value extremes and the error codes.
        directed_rows = '{
            row(ACT_ERASE,    0, 32'd0,        1, ST_BADPOS,   0, 0),
            row(ACT_MODIFY,   0, 32'd123,      1, ST_BADPOS,   0, 0),
            row(ACT_FIND,     0, 32'd0,        1, ST_NOTFOUND, 0, 0),
            row(ACT_INSERT,   1, 32'd9,        1, ST_BADPOS,   0, 0),
            row(ACT_INSERT, 511, 32'hFFFFFFFF, 1, ST_BADPOS,   0, 0),
            row(ACT_INSERT,   0, 32'h80000000, 1, ST_OK,       0, 1),
            row(ACT_INSERT,   1, 32'h7FFFFFFF, 1, ST_OK,       0, 2),
            row(ACT_INSERT,   0, 32'h00000000, 1, ST_OK,       0, 3),
            row(ACT_INSERT,   1, 32'hFFFFFFFF, 0, ST_OK,       0, 0),
            row(ACT_FIND,   511, 32'h7FFFFFFF, 1, ST_OK,       3, 4),
            row(ACT_FIND,     0, 32'h80000000, 0, ST_OK,       0, 0),
            row(ACT_FIND,     0, 32'd5,        1, ST_NOTFOUND, 0, 4),
            row(ACT_MODIFY,   3, 32'd5,        0, ST_OK,       0, 0),
            row(ACT_MODIFY,   4, 32'd6,        1, ST_BADPOS,   0, 4),
            row(ACT_MODIFY, 256, 32'd6,        1, ST_BADPOS,   0, 4),
            row(ACT_INSERT,   4, 32'd5,        0, ST_OK,       0, 0),
            row(ACT_FIND,     0, 32'd5,        0, ST_OK,       0, 0),
            row(ACT_INSERT,   6, 32'd1,        1, ST_BADPOS,   0, 5),
            row(ACT_ERASE,    5, 32'd0,        1, ST_BADPOS,   0, 5),
            row(ACT_ERASE,  511, 32'd0,        1, ST_BADPOS,   0, 5),
            row(ACT_ERASE,    0, 32'd0,        0, ST_OK,       0, 0),
            row(ACT_ERASE,    3, 32'd0,        0, ST_OK,       0, 0),
            row(ACT_ERASE,    1, 32'd0,        0, ST_OK,       0, 0),
            row(ACT_FIND,     0, 32'hFFFFFFFF, 0, ST_OK,       0, 0),
            row(ACT_ERASE,    0, 32'd0,        0, ST_OK,       0, 0),
            row(ACT_ERASE,    0, 32'd0,        0, ST_OK,       0, 0),
            row(ACT_FIND,     0, 32'd5,        1, ST_NOTFOUND, 0, 0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        tick();

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        // Mixed traffic while the list stays short.
        repeat (110)
            send_word(checked_row(pick_request()));

        // Grow the list to capacity, mostly with inserts at either end or
        // anywhere inside, with mixed random requests in between.
        while (list_len < CAPACITY)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 3))
                    0: send_word(checked_row(make_word(ACT_INSERT, 0, pick_value())));
                    1: send_word(checked_row(make_word(ACT_INSERT, list_len, pick_value())));
                    default: send_word(checked_row(make_word(ACT_INSERT,
                                       int'($urandom_range(0, list_len)), pick_value())));
                endcase
            end
            else
                send_word(checked_row(pick_request()));
        end

        // A full list: inserts are refused, while a position past the end
        // still reports a bad position ahead of the full check.
        repeat (6)
            send_word(checked_row(make_word(ACT_INSERT, int'($urandom_range(0, CAPACITY)),
                                            pick_value())));
        send_word(checked_row(make_word(ACT_INSERT, CAPACITY, pick_value())));
        send_word(checked_row(make_word(ACT_INSERT, int'($urandom_range(CAPACITY + 1, 511)),
                                        pick_value())));
        send_word(checked_row(make_word(ACT_MODIFY, CAPACITY - 1, 32'h5A5A_1234)));
        send_word(checked_row(make_word(ACT_FIND, 0, 32'h5A5A_1234)));
        send_word(checked_row(make_word(ACT_FIND, 0, $urandom)));
        send_word(checked_row(make_word(ACT_MODIFY, CAPACITY, pick_value())));
        send_word(checked_row(make_word(ACT_ERASE, CAPACITY, 32'd0)));
        send_word(checked_row(make_word(ACT_ERASE, CAPACITY - 1, 32'd0)));
        send_word(checked_row(make_word(ACT_INSERT, CAPACITY - 1, pick_value())));

        // Drain part of the list with erase-heavy traffic.
        repeat (40)
        begin
            if ($urandom_range(0, 9) < 6 && list_len > 0)
                send_word(checked_row(make_word(ACT_ERASE,
                                  int'($urandom_range(0, list_len - 1)), $urandom)));
            else
                send_word(checked_row(pick_request()));
        end

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            tick();
        repeat (TAIL_WAIT)
            tick();

        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/oal_pkg.sv
sv/oal_mem.sv
sv/oal_ctrl.sv
sv/ordered_array_list_engine.sv
test/tb.sv
